FILE: rtl/obms_pkg.sv
// ----------------------------------------------------------------------------
// obms_pkg: shared types and constants for the button mode selector
// Item types, configuration struct, qualifier phase codes and register indexes.
// ----------------------------------------------------------------------------
package obms_pkg;

    localparam int CFG_WIN_W  = 16;   // width of the window registers
    localparam int CFG_TOP_W  = 4;    // width of the top mode register
    localparam int CFG_IDX_W  = 2;    // width of the register index
    localparam int CFG_DATA_W = 16;   // width of the configuration data
    localparam int OUT_MODE_W = 4;    // width of the reported mode

    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_WINDOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_MODE       = 2'd2;

    localparam logic [CFG_WIN_W-1:0] RST_PRESS_WINDOW   = 16'd50;
    localparam logic [CFG_WIN_W-1:0] RST_RELEASE_WINDOW = 16'd50;
    localparam logic [CFG_TOP_W-1:0] RST_TOP_MODE       = 4'd2;

    // Input action codes.
    localparam logic ACT_PIN_CHANGE = 1'b0;
    localparam logic ACT_TICK       = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_SAMP = 2'd2,
        PH_QUAL = 2'd3
    } t_phase;

    typedef struct packed {
        logic action;
        logic pin_level;
    } t_in_item;

    typedef struct packed {
        logic [OUT_MODE_W-1:0] mode;
        logic [1:0]            phase;
        logic                  position_pressed;
        logic                  press_accepted;
    } t_out_item;

    typedef struct packed {
        logic [CFG_WIN_W-1:0] press_window;
        logic [CFG_WIN_W-1:0] release_window;
        logic [CFG_TOP_W-1:0] top_mode;
    } t_cfg;

endpackage

FILE: rtl/obms_cfg.sv
// ----------------------------------------------------------------------------
// obms_cfg: configuration register file
// Holds the press window, release window and top mode registers.
// ----------------------------------------------------------------------------
module obms_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [obms_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [obms_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output obms_pkg::t_cfg                   o_cfg
);

    obms_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_window   <= obms_pkg::RST_PRESS_WINDOW;
            r_cfg.release_window <= obms_pkg::RST_RELEASE_WINDOW;
            r_cfg.top_mode       <= obms_pkg::RST_TOP_MODE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                obms_pkg::CFG_PRESS_WINDOW: begin
                    r_cfg.press_window <= i_cfg_data[obms_pkg::CFG_WIN_W-1:0];
                end
                obms_pkg::CFG_RELEASE_WINDOW: begin
                    r_cfg.release_window <= i_cfg_data[obms_pkg::CFG_WIN_W-1:0];
                end
                obms_pkg::CFG_TOP_MODE: begin
                    r_cfg.top_mode <= i_cfg_data[obms_pkg::CFG_TOP_W-1:0];
                end
                default: begin
                    // Unused index: the write is dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/obms_core.sv
// ----------------------------------------------------------------------------
// obms_core: qualifier state and mode counter
// Updates the qualifier on each accepted item and forms its result.
// ----------------------------------------------------------------------------
module obms_core #(
    parameter int WINDOW_BITS = 16,
    parameter int MODE_BITS   = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  obms_pkg::t_in_item  i_item,
    input  obms_pkg::t_cfg      i_cfg,
    output obms_pkg::t_out_item o_result
);

    localparam int CMP_W  = (MODE_BITS + 1 > obms_pkg::CFG_TOP_W) ?
                            MODE_BITS + 1 : obms_pkg::CFG_TOP_W;
    localparam int MX_W   = (MODE_BITS > obms_pkg::OUT_MODE_W) ?
                            MODE_BITS : obms_pkg::OUT_MODE_W;
    localparam int EXT_W  = 32;

    obms_pkg::t_phase       r_phase,   n_phase;
    logic [WINDOW_BITS-1:0] r_window,  n_window;
    logic [WINDOW_BITS-1:0] r_samples, n_samples;
    logic                   r_pressed, n_pressed;
    logic [MODE_BITS-1:0]   r_mode,    n_mode;
    logic                   n_accepted;

    logic [EXT_W-1:0]       w_press_ext;
    logic [EXT_W-1:0]       w_release_ext;
    logic [WINDOW_BITS-1:0] w_load;
    logic [MODE_BITS:0]     w_mode_inc;
    logic [CMP_W-1:0]       w_inc_ext;
    logic [CMP_W-1:0]       w_top_ext;
    logic                   w_wrap;
    logic                   w_match;
    logic [MX_W-1:0]        w_mode_out;

    // Window loads keep the low WINDOW_BITS bits of the register value.
    assign w_press_ext   = EXT_W'(i_cfg.press_window);
    assign w_release_ext = EXT_W'(i_cfg.release_window);
    assign w_load        = r_pressed ? w_release_ext[WINDOW_BITS-1:0]
                                     : w_press_ext[WINDOW_BITS-1:0];

    // The increment carries into an extra bit so that overflow of the mode
    // counter itself also counts as passing the top mode.
    assign w_mode_inc = {1'b0, r_mode} + {{MODE_BITS{1'b0}}, 1'b1};
    assign w_inc_ext  = CMP_W'(w_mode_inc);
    assign w_top_ext  = CMP_W'(i_cfg.top_mode);
    assign w_wrap     = (w_inc_ext > w_top_ext) || w_mode_inc[MODE_BITS];

    assign w_match = r_pressed ? !i_item.pin_level : i_item.pin_level;

    always_comb begin
        n_phase    = r_phase;
        n_window   = r_window;
        n_samples  = r_samples;
        n_pressed  = r_pressed;
        n_mode     = r_mode;
        n_accepted = 1'b0;
        if (i_item.action == obms_pkg::ACT_PIN_CHANGE) begin
            if (r_phase == obms_pkg::PH_IDLE) begin
                n_phase = obms_pkg::PH_TRIG;
            end
        end else begin
            unique case (r_phase)
                obms_pkg::PH_TRIG: begin
                    n_phase   = obms_pkg::PH_SAMP;
                    n_pressed = !r_pressed;
                    n_window  = w_load;
                    n_samples = w_load >> 1;
                end
                obms_pkg::PH_SAMP: begin
                    if (r_window != '0) begin
                        n_window = r_window - 1'b1;
                        if (r_samples != '0 && w_match) begin
                            n_samples = r_samples - 1'b1;
                        end
                    end else if (r_samples != '0) begin
                        n_phase   = obms_pkg::PH_IDLE;
                        n_samples = '0;
                        n_window  = '0;
                    end else begin
                        n_phase = obms_pkg::PH_QUAL;
                    end
                end
                obms_pkg::PH_QUAL: begin
                    n_phase = obms_pkg::PH_IDLE;
                    if (r_pressed) begin
                        n_accepted = 1'b1;
                        if (w_wrap) begin
                            n_mode    = '0;
                            n_pressed = 1'b0;
                        end else begin
                            n_mode = w_mode_inc[MODE_BITS-1:0];
                        end
                    end
                end
                default: begin
                    // Idle: a tick changes nothing.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= obms_pkg::PH_IDLE;
            r_window  <= '0;
            r_samples <= '0;
            r_pressed <= 1'b0;
            r_mode    <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_window  <= n_window;
            r_samples <= n_samples;
            r_pressed <= n_pressed;
            r_mode    <= n_mode;
        end
    end

    assign w_mode_out = MX_W'(n_mode);

    always_comb begin
        o_result.mode             = w_mode_out[obms_pkg::OUT_MODE_W-1:0];
        o_result.phase            = n_phase;
        o_result.position_pressed = n_pressed;
        o_result.press_accepted   = n_accepted;
    end

endmodule

FILE: rtl/obms_outq.sv
// ----------------------------------------------------------------------------
// obms_outq: result register with skid stage
// Decouples the input stall from the output stall by one spare entry.
// ----------------------------------------------------------------------------
module obms_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  obms_pkg::t_out_item i_data,
    output logic                o_full,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output obms_pkg::t_out_item o_out_item
);

    logic                r_out_valid;
    logic                r_skid_valid;
    obms_pkg::t_out_item r_out_item;
    obms_pkg::t_out_item r_skid_item;
    logic                w_out_free;

    // The output register can be loaded when it is empty or being taken.
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_item <= r_skid_valid ? r_skid_item : i_data;
        end
        if (!w_out_free && i_push) begin
            r_skid_item <= i_data;
        end
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: rtl/oversampled_button_mode_selector_unit.sv
// ----------------------------------------------------------------------------
// oversampled_button_mode_selector_unit: debounced button mode selector
// Qualifies button presses by oversampling and steps a light mode counter.
// ----------------------------------------------------------------------------
// Usage. Each input item is either a pin-change event or a one millisecond
// tick carrying the sampled, active-low button level. Every accepted item
// produces exactly one result item giving the mode, the qualifier phase, the
// believed button position and whether this item completed a qualified press.
// The input channel is accepted when i_in_valid is high and o_in_stall is low;
// the output channel hands over an item when o_out_valid is high and
// i_out_stall is low. An accepted item's result is loaded into the output
// register, or into the skid entry while the receiver stalls. Throughput is
// one item per cycle while o_in_stall is low; the qualifier state is updated
// by a single pass of counter and compare logic. When the receiver stalls, a
// spare skid entry still takes one more item, and o_in_stall rises only once
// both the output register and that entry are full. The configuration port
// is always ready; registers should be written only while no items are in
// flight. Reset (synchronous, active low) returns the qualifier to idle, the
// position to released, the mode to off, empties both result entries and
// loads the register defaults.
// ----------------------------------------------------------------------------
module oversampled_button_mode_selector_unit #(
    parameter int WINDOW_BITS = 16,
    parameter int MODE_BITS   = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input item channel.
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  obms_pkg::t_in_item               i_in_item,
    // Result item channel.
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output obms_pkg::t_out_item              o_out_item,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [obms_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [obms_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    obms_pkg::t_cfg      w_cfg;
    obms_pkg::t_out_item w_result;
    logic                w_full;
    logic                w_accept;

    // Register writes never need to wait.
    assign o_cfg_ready = 1'b1;

    // The stall comes straight from the skid entry's flag, so it is a
    // register output and never depends on the incoming valid.
    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    obms_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    obms_core #(
        .WINDOW_BITS (WINDOW_BITS),
        .MODE_BITS   (MODE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    obms_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_accept),
        .i_data      (w_result),
        .o_full      (w_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: rtl/obms_checker.sv
// ----------------------------------------------------------------------------
// obms_checker: port-level checks for the button mode selector
// Watches the channels of the top level over time.
// ----------------------------------------------------------------------------
module obms_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  obms_pkg::t_out_item o_out_item
);

    // A stalled result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // A result only appears after an item was accepted.
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall))
        else $error("result without an accepted item");

    // The input is only stalled once a result has been held back.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

    // A completed press always leaves the qualifier idle.
    a_press_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.press_accepted |->
            o_out_item.phase == obms_pkg::PH_IDLE)
        else $error("press accepted outside idle phase");

endmodule

bind oversampled_button_mode_selector_unit obms_checker u_obms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

FILE: tb/sv/tb_oversampled_button_mode_selector_unit.sv
// ----------------------------------------------------------------------------
// tb_oversampled_button_mode_selector_unit: self-checking bench for the
// oversampled button mode selector
// A scoreboard class tracks the qualifier, the believed position and the mode
// for every item the block accepts, and compares each result item with the
// oldest outstanding prediction. Directed items cover idle ticks, ignored pin
// changes and zero-length windows; random press and release attempts with
// noisy pin samples then run under several register settings, with random
// gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------

class mode_selector_scoreboard;

    // Register copies.
    logic [obms_pkg::CFG_WIN_W-1:0]  press_len;
    logic [obms_pkg::CFG_WIN_W-1:0]  release_len;
    logic [obms_pkg::CFG_TOP_W-1:0]  top_limit;

    // Qualifier state as the block should hold it.
    obms_pkg::t_phase                phase_now;
    logic [obms_pkg::CFG_WIN_W-1:0]  window_left;
    logic [obms_pkg::CFG_WIN_W-1:0]  samples_left;
    logic                            held;
    logic [obms_pkg::OUT_MODE_W-1:0] mode_now;

    obms_pkg::t_out_item             awaited[$];
    int                              faults;

    function new();
        press_len    = obms_pkg::RST_PRESS_WINDOW;
        release_len  = obms_pkg::RST_RELEASE_WINDOW;
        top_limit    = obms_pkg::RST_TOP_MODE;
        phase_now    = obms_pkg::PH_IDLE;
        window_left  = '0;
        samples_left = '0;
        held         = 1'b0;
        mode_now     = '0;
        faults       = 0;
    endfunction

    task report_fault(string msg);
        $display("MISMATCH: %s", msg);
        faults++;
    endtask

    function void set_register(logic [obms_pkg::CFG_IDX_W-1:0]  idx,
                               logic [obms_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            obms_pkg::CFG_PRESS_WINDOW: begin
                press_len = data[obms_pkg::CFG_WIN_W-1:0];
            end
            obms_pkg::CFG_RELEASE_WINDOW: begin
                release_len = data[obms_pkg::CFG_WIN_W-1:0];
            end
            obms_pkg::CFG_TOP_MODE: begin
                top_limit = data[obms_pkg::CFG_TOP_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    // Advances the qualifier by one accepted item and queues the result it owes.
    function void take_event(obms_pkg::t_in_item it);
        obms_pkg::t_out_item           rep;
        logic                          accepted;
        logic [obms_pkg::OUT_MODE_W:0] next_mode;
        accepted = 1'b0;
        if (it.action == obms_pkg::ACT_PIN_CHANGE) begin
            if (phase_now == obms_pkg::PH_IDLE) begin
                phase_now = obms_pkg::PH_TRIG;
            end
        end else begin
            case (phase_now)
                obms_pkg::PH_TRIG: begin
                    phase_now    = obms_pkg::PH_SAMP;
                    held         = ~held;
                    window_left  = held ? press_len : release_len;
                    samples_left = window_left >> 1;
                end
                obms_pkg::PH_SAMP: begin
                    if (window_left != 0) begin
                        window_left = window_left - 1'b1;
                        // The pin is active low: a pressed button reads 0.
                        if (samples_left != 0 && it.pin_level == ~held) begin
                            samples_left = samples_left - 1'b1;
                        end
                    end else if (samples_left != 0) begin
                        phase_now    = obms_pkg::PH_IDLE;
                        samples_left = '0;
                        window_left  = '0;
                    end else begin
                        phase_now = obms_pkg::PH_QUAL;
                    end
                end
                obms_pkg::PH_QUAL: begin
                    phase_now = obms_pkg::PH_IDLE;
                    if (held) begin
                        accepted  = 1'b1;
                        next_mode = {1'b0, mode_now} + 1'b1;
                        // The top limit never exceeds the mode range, so this
                        // compare also covers overflow of the mode counter.
                        if (next_mode > {1'b0, top_limit}) begin
                            mode_now = '0;
                            held     = 1'b0;
                        end else begin
                            mode_now = next_mode[obms_pkg::OUT_MODE_W-1:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        rep.mode             = mode_now;
        rep.phase            = phase_now;
        rep.position_pressed = held;
        rep.press_accepted   = accepted;
        awaited.push_back(rep);
    endfunction

    task check_report(obms_pkg::t_out_item got);
        obms_pkg::t_out_item want;
        if (awaited.size() == 0) begin
            report_fault($sformatf("result item %h arrived with nothing outstanding", got));
            return;
        end
        want = awaited.pop_front();
        if (got.mode !== want.mode) begin
            report_fault($sformatf("mode %0d, expected %0d", got.mode, want.mode));
        end
        if (got.phase !== want.phase) begin
            report_fault($sformatf("phase %0d, expected %0d", got.phase, want.phase));
        end
        if (got.position_pressed !== want.position_pressed) begin
            report_fault($sformatf("position_pressed %b, expected %b",
                                   got.position_pressed, want.position_pressed));
        end
        if (got.press_accepted !== want.press_accepted) begin
            report_fault($sformatf("press_accepted %b, expected %b",
                                   got.press_accepted, want.press_accepted));
        end
    endtask

endclass

module tb_oversampled_button_mode_selector_unit;

    localparam int CYCLE_LIMIT = 200000;

    logic                            i_clk;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_stall;
    obms_pkg::t_in_item              i_in_item   = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    obms_pkg::t_out_item             o_out_item;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [obms_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [obms_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    mode_selector_scoreboard sb;
    int                      items_sent;
    int                      cycle_count;

    oversampled_button_mode_selector_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // A stretch in the middle of the run where no random gaps or stalls are drawn, so
    // that back-to-back traffic is exercised for several hundred items.
    function automatic bit calm_stretch();
        return items_sent >= 700 && items_sent < 1000;
    endfunction

    // Outside the calm stretch, the receiver stalls at random with nine percent probability.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= !calm_stretch() && ($urandom_range(99) < 9);
        end
    end

    // Every result handed over is checked against the oldest prediction. All
    // signals are read as they stood just before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_report(o_out_item);
        end
    end

    function automatic obms_pkg::t_in_item make_item(logic act, logic pin);
        obms_pkg::t_in_item it;
        it.action    = act;
        it.pin_level = pin;
        return it;
    endfunction

    // Presents one item, holds it steady until the block takes it, then lets
    // the scoreboard see it. Valid is left high so that the next call, made
    // in the same time step, either replaces the payload or opens a gap.
    task automatic send_item(input obms_pkg::t_in_item it);
        while (!calm_stretch() && $urandom_range(99) < 9) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        sb.take_event(it);
        items_sent++;
    endtask

    // Drops valid and waits until every outstanding result has been seen, so
    // that the registers may be rewritten safely.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.awaited.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2) @(posedge i_clk);
    endtask

    // Writes all three registers; the top mode carries random upper data bits,
    // which the block must ignore.
    task automatic load_settings(input logic [obms_pkg::CFG_WIN_W-1:0] press_len,
                                 input logic [obms_pkg::CFG_WIN_W-1:0] release_len,
                                 input logic [obms_pkg::CFG_TOP_W-1:0] top_limit);
        logic [obms_pkg::CFG_IDX_W-1:0]  idx [3];
        logic [obms_pkg::CFG_DATA_W-1:0] val [3];
        logic [obms_pkg::CFG_DATA_W-obms_pkg::CFG_TOP_W-1:0] junk;
        junk   = (obms_pkg::CFG_DATA_W-obms_pkg::CFG_TOP_W)'($urandom);
        idx[0] = obms_pkg::CFG_PRESS_WINDOW;
        idx[1] = obms_pkg::CFG_RELEASE_WINDOW;
        idx[2] = obms_pkg::CFG_TOP_MODE;
        val[0] = press_len;
        val[1] = release_len;
        val[2] = {junk, top_limit};
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do begin
                @(posedge i_clk);
            end while (!o_cfg_ready);
            sb.set_register(idx[k], val[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // One press or release attempt: a pin change, then ticks whose pin level
    // agrees with the believed position except for the given share of misses,
    // until the qualifier is idle again or the item budget runs out. Stray pin
    // changes are sprinkled in and must be ignored.
    task automatic drive_press_attempt(input int miss_pct, input int budget);
        obms_pkg::t_in_item it;
        int                 n;
        n = 0;
        send_item(make_item(obms_pkg::ACT_PIN_CHANGE, 1'($urandom_range(1))));
        do begin
            it.action    = obms_pkg::ACT_TICK;
            it.pin_level = ~sb.held;
            if ($urandom_range(99) < miss_pct) begin
                it.pin_level = ~it.pin_level;
            end
            if ($urandom_range(99) < 3) begin
                it.action = obms_pkg::ACT_PIN_CHANGE;
            end
            send_item(it);
            n++;
        end while (sb.phase_now != obms_pkg::PH_IDLE && n < budget);
    endtask

    // Mostly well-formed attempts, some with heavy pin noise, and occasional
    // short bursts of arbitrary items.
    task automatic run_phase(input logic [obms_pkg::CFG_WIN_W-1:0] press_len,
                             input logic [obms_pkg::CFG_WIN_W-1:0] release_len,
                             input logic [obms_pkg::CFG_TOP_W-1:0] top_limit,
                             input int count);
        int target;
        settle();
        load_settings(press_len, release_len, top_limit);
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(99) < 80) begin
                if ($urandom_range(99) < 70) begin
                    drive_press_attempt($urandom_range(10), target - items_sent);
                end else begin
                    drive_press_attempt($urandom_range(20, 60), target - items_sent);
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_item(make_item(1'($urandom_range(1)), 1'($urandom_range(1))));
                end
            end
        end
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        sb         = new();
        items_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Ticks while idle change nothing, whatever the pin says.
        send_item(make_item(obms_pkg::ACT_TICK, 1'b0));
        send_item(make_item(obms_pkg::ACT_TICK, 1'b1));

        // Zero-length windows qualify on the first sampling tick. With a top
        // mode of one, the first press steps to mode one and the second one
        // wraps to off and forces the position back to released. Pin changes
        // in every busy phase must be ignored.
        settle();
        load_settings('0, '0, 4'd1);
        send_item(make_item(obms_pkg::ACT_PIN_CHANGE, 1'b1));
        send_item(make_item(obms_pkg::ACT_PIN_CHANGE, 1'b0));
        send_item(make_item(obms_pkg::ACT_TICK, 1'b1));
        send_item(make_item(obms_pkg::ACT_PIN_CHANGE, 1'b1));
        send_item(make_item(obms_pkg::ACT_TICK, 1'b1));
        send_item(make_item(obms_pkg::ACT_PIN_CHANGE, 1'b0));
        send_item(make_item(obms_pkg::ACT_TICK, 1'b0));
        send_item(make_item(obms_pkg::ACT_PIN_CHANGE, 1'b0));
        send_item(make_item(obms_pkg::ACT_TICK, 1'b0));
        send_item(make_item(obms_pkg::ACT_TICK, 1'b0));
        send_item(make_item(obms_pkg::ACT_TICK, 1'b1));
        send_item(make_item(obms_pkg::ACT_PIN_CHANGE, 1'b1));
        send_item(make_item(obms_pkg::ACT_TICK, 1'b0));
        send_item(make_item(obms_pkg::ACT_TICK, 1'b0));
        send_item(make_item(obms_pkg::ACT_TICK, 1'b1));

        // The default windows, with full-length sampling.
        run_phase(obms_pkg::RST_PRESS_WINDOW, obms_pkg::RST_RELEASE_WINDOW,
                  obms_pkg::RST_TOP_MODE, 400);

        // One-tick windows need no samples, so every attempt qualifies and
        // the mode climbs through all values to the overflow wrap.
        run_phase(16'd1, 16'd1, 4'd15, 400);
        while (sb.mode_now < 3) begin
            drive_press_attempt(0, 16);
        end

        // The top mode now lies below the current mode: the next accepted
        // press must wrap to off.
        run_phase(16'd3, 16'd2, 4'd1, 250);

        repeat (3) begin
            run_phase(16'($urandom_range(2, 20)), 16'($urandom_range(2, 20)),
                      4'($urandom_range(1, 15)), 150);
        end

        // Longest windows; the run ends part way through sampling.
        run_phase(16'hFFFF, 16'hFFFF, 4'd15, 60);

        settle();
        repeat (4) @(posedge i_clk);
        if (sb.faults == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/obms_pkg.sv
rtl/obms_cfg.sv
rtl/obms_core.sv
rtl/obms_outq.sv
rtl/oversampled_button_mode_selector_unit.sv
rtl/obms_checker.sv
tb/sv/tb_oversampled_button_mode_selector_unit.sv
